FILE: rtl/core/uhodr_pkg.sv
// Shared types, constants and the month length table for the hour offset
// and date rollover core. No dependencies.

package uhodr_pkg;

   localparam int unsigned YEAR_W   = 12;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned DAY_IN_W = 5;
   localparam int unsigned DAY_W    = 6;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MIN_W    = 6;
   localparam int unsigned SEC_W    = 6;
   localparam int unsigned YOC_W    = 7;

   localparam logic [HOUR_W-1:0]  HOUR_OFFSET_RESET = 5'd21;
   localparam logic [HOUR_W:0]    HOURS_PER_DAY     = 6'd24;
   localparam logic [MONTH_W-1:0] MONTH_FEB         = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC         = 4'd12;
   localparam logic [MONTH_W-1:0] MONTH_JAN         = 4'd1;
   localparam logic [DAY_W-1:0]   DAYS_FEB_LEAP     = 6'd29;
   localparam logic [YEAR_W-1:0]  YEAR_BASE         = 12'd2000;

   // Divisibility by 25 on a 12-bit year: multiply by the inverse of 25
   // modulo 4096, a multiple of 25 lands at or below 4095/25.
   localparam logic [YEAR_W-1:0]  INV25_MOD       = 12'd3113;
   localparam logic [YEAR_W-1:0]  DIV25_THRESHOLD = 12'd163;

   typedef struct packed {
      logic [YEAR_W-1:0]   full_year;
      logic [MONTH_W-1:0]  month_in;
      logic [DAY_IN_W-1:0] day_in;
      logic [HOUR_W-1:0]   hour_in;
      logic [MIN_W-1:0]    minute_in;
      logic [SEC_W-1:0]    second_in;
   } request_type;

   typedef struct packed {
      logic                status;
      logic [YOC_W-1:0]    year_of_century;
      logic [MONTH_W-1:0]  month_out;
      logic [DAY_W-1:0]    day_out;
      logic [HOUR_W-1:0]   hour_out;
      logic [MIN_W-1:0]    minute_out;
      logic [SEC_W-1:0]    second_out;
   } result_type;

   // Days in a common year; codes outside 1..12 never reach a lookup that counts.
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] days;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 6'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    days = 6'd30;
         4'd2:                                       days = 6'd28;
         default:                                    days = 6'd0;
      endcase
      return days;
   endfunction

endpackage

FILE: rtl/core/uhodr_leap.sv
// Gregorian leap year test on a 12-bit binary year.
// Depends on uhodr_pkg.

module uhodr_leap (
   input  logic [uhodr_pkg::YEAR_W-1:0] year,
   output logic                         leap
);

   logic [2*uhodr_pkg::YEAR_W-1:0] prod;
   logic                           div25;

   // Constant multiply, low bits only.
   assign prod  = {{uhodr_pkg::YEAR_W{1'b0}}, year}
                * {{uhodr_pkg::YEAR_W{1'b0}}, uhodr_pkg::INV25_MOD};
   assign div25 = (prod[uhodr_pkg::YEAR_W-1:0] <= uhodr_pkg::DIV25_THRESHOLD);

   // Divisible by 4 and, if also by 100, by 400 too.
   assign leap = (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));

endmodule

FILE: rtl/core/uhodr_calc.sv
// Combinational hour offset, day, month and year rollover for one request.
// Depends on uhodr_pkg and uhodr_leap.

module uhodr_calc (
   input  uhodr_pkg::request_type             req,
   input  logic [uhodr_pkg::HOUR_W-1:0]       hour_offset,
   output uhodr_pkg::result_type              rsp
);

   logic [uhodr_pkg::HOUR_W:0]    hour_sum;
   logic [uhodr_pkg::HOUR_W:0]    hour_once;
   logic [uhodr_pkg::HOUR_W:0]    hour_twice;
   logic                          rollover;
   logic                          month_bad;
   logic                          leap;
   logic [uhodr_pkg::DAY_W-1:0]   day_next;
   logic [uhodr_pkg::DAY_W-1:0]   month_len;
   logic [uhodr_pkg::YEAR_W-1:0]  year_new;
   logic [uhodr_pkg::YEAR_W-1:0]  year_rel;

   uhodr_leap u_leap (
      .year (req.full_year),
      .leap (leap)
   );

   assign hour_sum   = {1'b0, req.hour_in} + {1'b0, hour_offset};
   assign rollover   = (hour_sum >= uhodr_pkg::HOURS_PER_DAY);
   assign hour_once  = hour_sum - uhodr_pkg::HOURS_PER_DAY;
   assign hour_twice = (hour_once >= uhodr_pkg::HOURS_PER_DAY)
                     ? hour_once - uhodr_pkg::HOURS_PER_DAY : hour_once;

   assign month_bad = (req.month_in == '0) || (req.month_in > uhodr_pkg::MONTH_DEC);
   assign day_next  = {1'b0, req.day_in} + 6'd1;
   assign month_len = (req.month_in == uhodr_pkg::MONTH_FEB && leap)
                    ? uhodr_pkg::DAYS_FEB_LEAP : uhodr_pkg::month_days(req.month_in);

   always_comb begin
      rsp            = '0;
      year_new       = req.full_year;
      rsp.month_out  = req.month_in;
      rsp.day_out    = {1'b0, req.day_in};
      rsp.hour_out   = hour_sum[uhodr_pkg::HOUR_W-1:0];
      rsp.minute_out = req.minute_in;
      rsp.second_out = req.second_in;
      if (rollover) begin
         rsp.hour_out = hour_twice[uhodr_pkg::HOUR_W-1:0];
         rsp.day_out  = day_next;
         if (day_next > month_len) begin
            rsp.day_out = 6'd1;
            if (req.month_in == uhodr_pkg::MONTH_DEC) begin
               rsp.month_out = uhodr_pkg::MONTH_JAN;
               year_new      = req.full_year + 12'd1;
            end else begin
               rsp.month_out = req.month_in + 4'd1;
            end
         end
      end
      year_rel            = year_new - uhodr_pkg::YEAR_BASE;
      rsp.year_of_century = year_rel[uhodr_pkg::YOC_W-1:0];
      // Bad month seen on a day rollover: flag and zero everything else.
      if (rollover && month_bad) begin
         rsp        = '0;
         rsp.status = 1'b1;
      end
   end

endmodule

FILE: rtl/core/utc_hour_offset_date_rollover_core.sv
// Hour offset with Gregorian date rollover: request register, calculation,
// result register. Depends on uhodr_pkg and uhodr_calc.

// One request per clock cycle, sustained while rsp_ready stays high. A request
// passes through the request register and then the result register, with the
// hour offset, the leap year test and the day, month and year rollover done
// in the logic between them. req_ready follows rsp_ready combinationally when
// both registers are full. The hour_offset register (reset 21) is written
// through the csr_ channel, which is always ready; write it only while no
// request is in flight. A month outside 1..12 is checked only when the hour
// rolls into the next day, and then gives status 1 with all other fields zero.

module utc_hour_offset_date_rollover_core (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [uhodr_pkg::HOUR_W-1:0]      csr_hour_offset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [uhodr_pkg::YEAR_W-1:0]      req_full_year,
   input  logic [uhodr_pkg::MONTH_W-1:0]     req_month_in,
   input  logic [uhodr_pkg::DAY_IN_W-1:0]    req_day_in,
   input  logic [uhodr_pkg::HOUR_W-1:0]      req_hour_in,
   input  logic [uhodr_pkg::MIN_W-1:0]       req_minute_in,
   input  logic [uhodr_pkg::SEC_W-1:0]       req_second_in,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_status,
   output logic [uhodr_pkg::YOC_W-1:0]       rsp_year_of_century,
   output logic [uhodr_pkg::MONTH_W-1:0]     rsp_month_out,
   output logic [uhodr_pkg::DAY_W-1:0]       rsp_day_out,
   output logic [uhodr_pkg::HOUR_W-1:0]      rsp_hour_out,
   output logic [uhodr_pkg::MIN_W-1:0]       rsp_minute_out,
   output logic [uhodr_pkg::SEC_W-1:0]       rsp_second_out
);

   logic [uhodr_pkg::HOUR_W-1:0] hour_offset_ff;
   logic [uhodr_pkg::HOUR_W-1:0] hour_offset_in;

   logic                         req_valid_ff;
   logic                         req_valid_in;
   uhodr_pkg::request_type       req_ff;
   uhodr_pkg::request_type       req_in;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   uhodr_pkg::result_type        rsp_ff;
   uhodr_pkg::result_type        calc_rsp;

   logic                         rsp_free;
   logic                         req_advance;

   assign csr_ready = 1'b1;

   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign req_advance = req_valid_ff && rsp_free;
   assign req_ready   = !req_valid_ff || rsp_free;

   assign hour_offset_in = (csr_valid && csr_ready) ? csr_hour_offset : hour_offset_ff;
   assign req_valid_in   = req_ready ? req_valid : req_valid_ff;
   assign rsp_valid_in   = rsp_free ? req_valid_ff : rsp_valid_ff;

   assign req_in = '{full_year: req_full_year, month_in: req_month_in,
                     day_in: req_day_in, hour_in: req_hour_in,
                     minute_in: req_minute_in, second_in: req_second_in};

   uhodr_calc u_calc (
      .req         (req_ff),
      .hour_offset (hour_offset_ff),
      .rsp         (calc_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_offset_ff <= uhodr_pkg::HOUR_OFFSET_RESET;
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         hour_offset_ff <= hour_offset_in;
         req_valid_ff   <= req_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers load only on a transfer into their stage.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_in;
      end
      if (req_advance) begin
         rsp_ff <= calc_rsp;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_year_of_century = rsp_ff.year_of_century;
   assign rsp_month_out       = rsp_ff.month_out;
   assign rsp_day_out         = rsp_ff.day_out;
   assign rsp_hour_out        = rsp_ff.hour_out;
   assign rsp_minute_out      = rsp_ff.minute_out;
   assign rsp_second_out      = rsp_ff.second_out;

`ifndef SYNTHESIS
   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_year_of_century == '0 && rsp_month_out == '0
         && rsp_day_out == '0 && rsp_hour_out == '0 && rsp_minute_out == '0
         && rsp_second_out == '0)
      else $error("error response carries nonzero fields");

   a_hour_wrapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status |-> rsp_hour_out < uhodr_pkg::HOURS_PER_DAY[uhodr_pkg::HOUR_W-1:0])
      else $error("hour not wrapped below 24");

   a_request_held: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> req_valid_ff)
      else $error("accepted request lost from request register");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && rsp_free |=> rsp_valid)
      else $error("advanced request produced no result");
`endif

endmodule
